// ===== hdl/aars_pkg.sv =====
// ----------------------------------------------------------------------------
// aars_pkg : shared types and constants of the ANSI art row extent scanner
// Byte codes, parse phase codes, register map and the input item type.
// ----------------------------------------------------------------------------
`default_nettype none

package aars_pkg;

    // Widths of the item fields and of the cursor state
    localparam int BYTE_W = 8;
    localparam int ROW_W  = 16;
    localparam int COL_W  = 8;

    // Register map (byte address 4*index)
    localparam int APB_ADDR_W = 3;
    localparam logic [0:0] REG_ART_WIDTH = 1'd0;
    localparam logic [COL_W-1:0] ART_WIDTH_RESET = 8'd80;

    // Parse phases
    localparam logic [1:0] PH_GROUND = 2'd0;
    localparam logic [1:0] PH_ESC    = 2'd1;
    localparam logic [1:0] PH_CSI_P1 = 2'd2;
    localparam logic [1:0] PH_CSI_P2 = 2'd3;

    // Byte codes
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_CUU   = 8'h41;
    localparam logic [BYTE_W-1:0] CH_CUD   = 8'h42;
    localparam logic [BYTE_W-1:0] CH_CUF   = 8'h43;
    localparam logic [BYTE_W-1:0] CH_CUB   = 8'h44;
    localparam logic [BYTE_W-1:0] CH_CUP_H = 8'h48;
    localparam logic [BYTE_W-1:0] CH_ED    = 8'h4A;
    localparam logic [BYTE_W-1:0] CH_CUP_F = 8'h66;

    localparam logic [ROW_W-1:0] SAT16 = 16'hFFFF;

    // One input item as held in the input register
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_art;
    } item_t;

endpackage : aars_pkg

`default_nettype wire

// ===== hdl/aars_scan.sv =====
// ----------------------------------------------------------------------------
// aars_scan : cursor tracker and escape parser
// Holds the cursor, high mark and CSI parse state; advances them by one byte
// whenever step is high and presents the high mark after that byte.
// ----------------------------------------------------------------------------
`default_nettype none

module aars_scan (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       step,
    input  wire aars_pkg::item_t            item,
    input  wire logic [aars_pkg::COL_W-1:0] art_width,
    output logic      [aars_pkg::ROW_W-1:0] row_mark
);

    logic [aars_pkg::ROW_W-1:0] row_reg, row_next;
    logic [aars_pkg::COL_W-1:0] col_reg, col_next;
    logic [aars_pkg::ROW_W-1:0] mark_reg, mark_next;
    logic [1:0]                 phase_reg, phase_next;
    logic [aars_pkg::ROW_W-1:0] pval_reg, pval_next;
    logic                       seen_reg, seen_next;

    // Next state for one byte
    always_comb begin
        logic [aars_pkg::BYTE_W-1:0] b;
        logic [aars_pkg::COL_W-1:0]  width_eff;
        logic [aars_pkg::COL_W-1:0]  width_m1;
        logic [aars_pkg::ROW_W-1:0]  count;
        logic [aars_pkg::ROW_W-1:0]  row_inc;
        logic                        ground_hit;
        logic                        is_digit;
        logic [3:0]                  digit;
        logic [19:0]                 acc;
        logic [aars_pkg::ROW_W:0]    row_sum;
        logic [aars_pkg::ROW_W:0]    col_sum;
        logic [aars_pkg::COL_W:0]    col_inc;

        b          = item.data_byte;
        width_eff  = (art_width == '0) ? 8'd1 : art_width;
        width_m1   = width_eff - 8'd1;
        count      = (seen_reg && (pval_reg != '0)) ? pval_reg : 16'd1;
        row_inc    = (row_reg == aars_pkg::SAT16) ? row_reg : row_reg + 16'd1;
        ground_hit = 1'b0;
        is_digit   = (b >= aars_pkg::CH_ZERO) && (b <= aars_pkg::CH_NINE);
        digit      = 4'(b - aars_pkg::CH_ZERO);
        acc        = {1'b0, pval_reg, 3'b000} + {3'b000, pval_reg, 1'b0} + {16'd0, digit};
        row_sum    = {1'b0, row_reg} + {1'b0, count};
        col_sum    = {9'd0, col_reg} + {1'b0, count};
        col_inc    = {1'b0, col_reg} + 9'd1;

        row_next   = row_reg;
        col_next   = col_reg;
        phase_next = phase_reg;
        pval_next  = pval_reg;
        seen_next  = seen_reg;

        unique case (phase_reg)
            aars_pkg::PH_GROUND: begin
                ground_hit = 1'b1;
            end
            aars_pkg::PH_ESC: begin
                if (b == aars_pkg::CH_LBRK) begin
                    phase_next = aars_pkg::PH_CSI_P1;
                    pval_next  = '0;
                    seen_next  = 1'b0;
                end else begin
                    // drop the lone ESC, treat this byte as ordinary
                    phase_next = aars_pkg::PH_GROUND;
                    ground_hit = 1'b1;
                end
            end
            aars_pkg::PH_CSI_P1: begin
                if (is_digit) begin
                    if (!seen_reg) begin
                        pval_next = {12'd0, digit};
                    end else if (acc > {4'd0, aars_pkg::SAT16}) begin
                        pval_next = aars_pkg::SAT16;
                    end else begin
                        pval_next = acc[aars_pkg::ROW_W-1:0];
                    end
                    seen_next = 1'b1;
                end else if (b == aars_pkg::CH_SEMI) begin
                    // keep the target row; seen now flags a void sequence
                    pval_next  = count;
                    seen_next  = 1'b0;
                    phase_next = aars_pkg::PH_CSI_P2;
                end else begin
                    phase_next = aars_pkg::PH_GROUND;
                    pval_next  = '0;
                    seen_next  = 1'b0;
                    if (b == aars_pkg::CH_CUD) begin
                        row_next = row_sum[aars_pkg::ROW_W] ? aars_pkg::SAT16
                                                            : row_sum[aars_pkg::ROW_W-1:0];
                    end else if (b == aars_pkg::CH_CUF) begin
                        if (col_sum >= {9'd0, width_m1}) begin
                            row_next = row_inc;
                            col_next = '0;
                        end else begin
                            col_next = col_sum[aars_pkg::COL_W-1:0];
                        end
                    end else if (b == aars_pkg::CH_CUB) begin
                        col_next = ({8'd0, col_reg} > count)
                                   ? col_reg - count[aars_pkg::COL_W-1:0] : '0;
                    end else if ((b == aars_pkg::CH_ED) && seen_reg && (pval_reg == 16'd2)) begin
                        row_next = '0;
                        col_next = '0;
                    end
                end
            end
            aars_pkg::PH_CSI_P2: begin
                if (is_digit) begin
                    // column parameter has no effect on the row extent
                end else if (b == aars_pkg::CH_SEMI) begin
                    seen_next = 1'b1;
                end else begin
                    if (((b == aars_pkg::CH_CUP_H) || (b == aars_pkg::CH_CUP_F)) && !seen_reg) begin
                        row_next = pval_reg - 16'd1;
                    end
                    phase_next = aars_pkg::PH_GROUND;
                    pval_next  = '0;
                    seen_next  = 1'b0;
                end
            end
            default: begin
                phase_next = aars_pkg::PH_GROUND;
            end
        endcase

        // Ordinary byte: line feed, carriage return, printable or NUL, escape
        if (ground_hit) begin
            if (b == aars_pkg::CH_LF) begin
                row_next = row_inc;
                col_next = '0;
            end else if (b == aars_pkg::CH_CR) begin
                col_next = '0;
            end else if ((b >= aars_pkg::CH_SPACE) || (b == aars_pkg::CH_NUL)) begin
                if (col_inc >= {1'b0, width_eff}) begin
                    row_next = row_inc;
                    col_next = '0;
                end else begin
                    col_next = col_inc[aars_pkg::COL_W-1:0];
                end
            end else if (b == aars_pkg::CH_ESC) begin
                phase_next = aars_pkg::PH_ESC;
            end
        end

        // The high mark only climbs: it keeps the deepest row reached so far
        mark_next = (row_next > mark_reg) ? row_next : mark_reg;
    end

    assign row_mark = mark_next;

    // Advance on each step; clear everything after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= '0;
            col_reg   <= '0;
            mark_reg  <= '0;
            phase_reg <= aars_pkg::PH_GROUND;
            pval_reg  <= '0;
            seen_reg  <= 1'b0;
        end else if (step) begin
            if (item.end_of_art) begin
                row_reg   <= '0;
                col_reg   <= '0;
                mark_reg  <= '0;
                phase_reg <= aars_pkg::PH_GROUND;
                pval_reg  <= '0;
                seen_reg  <= 1'b0;
            end else begin
                row_reg   <= row_next;
                col_reg   <= col_next;
                mark_reg  <= mark_next;
                phase_reg <= phase_next;
                pval_reg  <= pval_next;
                seen_reg  <= seen_next;
            end
        end
    end

endmodule : aars_scan

`default_nettype wire

// ===== hdl/ansi_art_row_extent_scanner.sv =====
// ----------------------------------------------------------------------------
// ansi_art_row_extent_scanner : deepest row reached by an ANSI art stream
// Input register, one-byte scanner and result register, plus the width
// register on an APB-style port.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                        Transfer when
//  s_*       in         tdata: data_byte, tlast: end   s_tvalid & s_tready
//  m_*       out        tdata: deepest_row             m_tvalid & m_tready
//  APB       in/out     art_width at address 0         psel&penable&pwrite
//
//  One byte per cycle unless the input side is held; each byte waits in the
//  input register and is folded into the cursor state by the scanner update.
//  A result is registered in the cycle after its last byte is folded in.
//  Reset (aresetn low, synchronous) clears the state and both registers;
//  width returns to 80. Only a last byte meeting a full, stalled result
//  register holds the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module ansi_art_row_extent_scanner (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] data_byte
    input  wire logic                            s_tlast,   // end_of_art
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [15:0]                     m_tdata,   // [15:0] deepest_row
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [aars_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);

    logic                       in_valid_reg;
    aars_pkg::item_t            in_item_reg;
    logic                       out_valid_reg;
    logic [aars_pkg::ROW_W-1:0] out_row_reg;
    logic [aars_pkg::COL_W-1:0] width_reg;
    logic                       step;
    logic [aars_pkg::ROW_W-1:0] row_mark;
    logic                       reg_sel;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[aars_pkg::APB_ADDR_W-1:2] == aars_pkg::REG_ART_WIDTH);
    assign prdata  = reg_sel ? {24'd0, width_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= aars_pkg::ART_WIDTH_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            width_reg <= pwdata[aars_pkg::COL_W-1:0];
        end
    end

    // Advance the held byte unless it is a last byte facing a stalled result
    assign step     = in_valid_reg && (!in_item_reg.end_of_art || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.data_byte  <= s_tdata;
            in_item_reg.end_of_art <= s_tlast;
        end
    end

    aars_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (in_item_reg),
        .art_width (width_reg),
        .row_mark  (row_mark)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && in_item_reg.end_of_art) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && in_item_reg.end_of_art) begin
            out_row_reg <= row_mark;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_row_reg;

endmodule : ansi_art_row_extent_scanner

`default_nettype wire

// ===== hdl/aars_checker.sv =====
// ----------------------------------------------------------------------------
// aars_checker : port-level checks for the row extent scanner
// Watches the stream and configuration ports; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module aars_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [15:0]                     m_tdata,
    input wire logic                            psel,
    input wire logic                            penable,
    input wire logic                            pwrite,
    input wire logic [aars_pkg::APB_ADDR_W-1:0] paddr,
    input wire logic [31:0]                     pwdata,
    input wire logic [31:0]                     prdata
);

    // Hold a stalled result
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // With no result waiting the input side never stalls
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // A width write reads back
    a_width_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && (paddr[aars_pkg::APB_ADDR_W-1:2] == aars_pkg::REG_ART_WIDTH)
        |=> (paddr[aars_pkg::APB_ADDR_W-1:2] != aars_pkg::REG_ART_WIDTH)
            || (prdata[7:0] == $past(pwdata[7:0])))
        else $error("width register read-back mismatch");

endmodule : aars_checker

bind ansi_art_row_extent_scanner aars_checker u_aars_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);

`default_nettype wire
